// File: rtl/core/cpmd_pkg.sv
package cpmd_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int PT_W       = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int MAG_W      = PT_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int DSQ_W      = SQ_W + 1;
  localparam int FRAC_W     = 8;
  localparam int ROOT_W     = (DSQ_W + 2 * FRAC_W + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int STEP_W     = $clog2(ROOT_W + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH_I,
    ST_WAIT_I,
    ST_WALK,
    ST_DRAIN,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [PT_W-1:0]   wr_x;
    logic [PT_W-1:0]   wr_y;
    logic [IDX_W-1:0]  rd_addr;
  } store_req_t;

endpackage

// File: rtl/core/cpmd_if.sv
interface point_if;
  import cpmd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic                   last_point;

  modport source(output valid, output point_x, output point_y, output last_point,
                 input ready);
  modport sink(input valid, input point_x, input point_y, input last_point,
               output ready);
endinterface

interface result_if;
  import cpmd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DSQ_W-1:0]  min_dist_squared;
  logic [ROOT_W-1:0] min_distance;
  logic              no_pair;
  logic              overflowed;

  modport source(output valid, output min_dist_squared, output min_distance,
                 output no_pair, output overflowed, input ready);
  modport sink(input valid, input min_dist_squared, input min_distance,
               input no_pair, input overflowed, output ready);
endinterface

// File: rtl/core/cpmd_store.sv
// Point memory: x and y packed in one word, one write and one read port,
// registered read data.
module cpmd_store
  import cpmd_pkg::*;
(
  input  logic            clk,
  input  store_req_t      req,
  output logic [PT_W-1:0] rd_x,
  output logic [PT_W-1:0] rd_y
);

  logic [2*PT_W-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= {req.wr_x, req.wr_y};
    end
  end

  always_ff @(posedge clk) begin
    {rd_x, rd_y} <= mem[req.rd_addr];
  end

endmodule

// File: rtl/core/cpmd_dist.sv
// Pair distance pipeline: |dx|,|dy| -> squares -> sum and running minimum.
module cpmd_dist
  import cpmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              in_valid,
  input  logic [PT_W-1:0]   ref_x,
  input  logic [PT_W-1:0]   ref_y,
  input  logic [PT_W-1:0]   cand_x,
  input  logic [PT_W-1:0]   cand_y,
  output logic              busy,
  output logic [DSQ_W-1:0]  best
);

  logic             v1;
  logic             v2;
  logic             have;
  logic [MAG_W-1:0] mag_x;
  logic [MAG_W-1:0] mag_y;
  logic [SQ_W-1:0]  sq_x;
  logic [SQ_W-1:0]  sq_y;
  logic [PT_W:0]    dx;
  logic [PT_W:0]    dy;
  logic [DSQ_W-1:0] sum;

  always_comb begin
    dx  = {ref_x[PT_W-1], ref_x} - {cand_x[PT_W-1], cand_x};
    dy  = {ref_y[PT_W-1], ref_y} - {cand_y[PT_W-1], cand_y};
    sum = {1'b0, sq_x} + {1'b0, sq_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      have <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      if (clear) begin
        have <= 1'b0;
      end else if (v2) begin
        have <= 1'b1;
      end
    end
    // magnitude of a 17-bit difference fits in 16 bits
    mag_x <= dx[PT_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
    mag_y <= dy[PT_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
    sq_x  <= mag_x * mag_x;
    sq_y  <= mag_y * mag_y;
    if (v2 && (!have || sum < best)) begin
      best <= sum;
    end
  end

  assign busy = v1 | v2;

endmodule

// File: rtl/core/cpmd_sqrt.sv
// Digit-by-digit square root of value * 2^16, one result bit per cycle.
module cpmd_sqrt
  import cpmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DSQ_W-1:0]  value,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic              run;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && steps == STEP_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      rad   <= RAD_W'({value, {(2 * FRAC_W){1'b0}}});
      rem   <= '0;
      root  <= '0;
      steps <= STEP_W'(ROOT_W);
    end else if (run) begin
      rad   <= {rad[RAD_W-3:0], 2'b00};
      rem   <= fits ? rem_sh - trial : rem_sh;
      root  <= {root[ROOT_W-2:0], fits};
      steps <= steps - STEP_W'(1);
    end
  end

endmodule

// File: rtl/core/closest_pair_min_distance_top.sv
// Sequence: after the last point, the search walks every pair of the set, one pair
//   per cycle from the single memory read port, with a row fetch between rows;
//   then the square root runs and the result word registers.
// Throughput: one point word per cycle while loading; one set at a time.
// Reset: rst is synchronous, active high; clears point count, overflow flag, FSM
//   and output valid. The point memory is not cleared: only entries of the set are read.
module closest_pair_min_distance_top
  import cpmd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  point_if.sink     pt,
  result_if.source  res
);

  // Control state
  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic              ovf;
  logic [IDX_W-1:0]  i_idx;
  logic [IDX_W-1:0]  j_idx;
  logic [IDX_W-1:0]  last_idx;
  logic              pair_ok;
  logic              issue_d;

  // Reference point of the current row of the pair walk
  logic [PT_W-1:0]   pi_x;
  logic [PT_W-1:0]   pi_y;

  // Output word register
  logic              out_valid;
  logic [DSQ_W-1:0]  out_dsq;
  logic [ROOT_W-1:0] out_root;
  logic              out_no_pair;
  logic              out_ovf;

  // Datapath hookups
  store_req_t        sreq;
  logic [PT_W-1:0]   rd_x;
  logic [PT_W-1:0]   rd_y;
  logic              dist_busy;
  logic [DSQ_W-1:0]  best;
  logic              sqrt_done;
  logic [ROOT_W-1:0] root;

  // Decoded controls
  logic              accept;
  logic              full;
  logic [CNT_W-1:0]  count_after;
  logic              issue;
  logic              drained;
  logic              sqrt_start;
  logic              emit;

  assign full        = (count == CNT_W'(MAX_POINTS));
  assign count_after = full ? count : count + CNT_W'(1);
  assign accept      = pt.valid && pt.ready;
  assign drained     = !issue_d && !dist_busy;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && pt.last_point) begin
          // fewer than two points: no search, straight to the result
          state_next = (count_after >= CNT_W'(2)) ? ST_FETCH_I : ST_DONE;
        end
      end
      ST_FETCH_I: state_next = ST_WAIT_I;
      ST_WAIT_I:  state_next = ST_WALK;
      ST_WALK: begin
        if (j_idx == last_idx) begin
          state_next = (i_idx + IDX_W'(1) == last_idx) ? ST_DRAIN : ST_FETCH_I;
        end
      end
      ST_DRAIN: begin
        if (drained) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || res.ready) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pt.ready     = (state == ST_LOAD);
    issue        = (state == ST_WALK);
    sqrt_start   = (state == ST_DRAIN) && drained;
    emit         = (state == ST_DONE) && (!out_valid || res.ready);
    sreq.wr_en   = accept && !full;
    sreq.wr_addr = count[IDX_W-1:0];
    sreq.wr_x    = pt.point_x;
    sreq.wr_y    = pt.point_y;
    sreq.rd_addr = (state == ST_FETCH_I) ? i_idx : j_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      issue_d   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      issue_d <= issue;
      if (emit) begin
        count     <= '0;
        ovf       <= 1'b0;
        out_valid <= 1'b1;
      end else begin
        if (accept) begin
          count <= count_after;
          if (full) begin
            ovf <= 1'b1;
          end
        end
        if (res.ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // Walk indices and payload registers
  always_ff @(posedge clk) begin
    if (accept && pt.last_point) begin
      pair_ok  <= (count_after >= CNT_W'(2));
      last_idx <= IDX_W'(count_after - CNT_W'(1));
      i_idx    <= '0;
    end
    if (state == ST_WAIT_I) begin
      pi_x  <= rd_x;
      pi_y  <= rd_y;
      j_idx <= i_idx + IDX_W'(1);
    end
    if (state == ST_WALK) begin
      if (j_idx == last_idx) begin
        i_idx <= i_idx + IDX_W'(1);
      end else begin
        j_idx <= j_idx + IDX_W'(1);
      end
    end
    if (emit) begin
      out_no_pair <= !pair_ok;
      out_ovf     <= ovf;
      out_dsq     <= pair_ok ? best : '0;
      out_root    <= pair_ok ? root : '0;
    end
  end

  cpmd_store u_store (
    .clk  (clk),
    .req  (sreq),
    .rd_x (rd_x),
    .rd_y (rd_y)
  );

  cpmd_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .clear    (accept && pt.last_point),
    .in_valid (issue_d),
    .ref_x    (pi_x),
    .ref_y    (pi_y),
    .cand_x   (rd_x),
    .cand_y   (rd_y),
    .busy     (dist_busy),
    .best     (best)
  );

  cpmd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (best),
    .done  (sqrt_done),
    .root  (root)
  );

  assign res.valid            = out_valid;
  assign res.min_dist_squared = out_dsq;
  assign res.min_distance     = out_root;
  assign res.no_pair          = out_no_pair;
  assign res.overflowed       = out_ovf;

endmodule

// File: dv/closest_pair_min_distance_top_tb.sv
`timescale 1ns / 100ps

module closest_pair_min_distance_top_tb;
  import cpmd_pkg::*;

  // Idle percentages per traffic mix
  localparam int HEAVY_PCT   = 63;
  localparam int LIGHT_PCT   = 31;
  // Long receiver hold-off in the pressure mix, in clock cycles
  localparam int HOLD_CYCLES = 2000;
  // Quiet cycles after the last result before the verdict
  localparam int TAIL_CYCLES = 100;
  // Items per random traffic mix
  localparam int MIX_ITEMS   = 60;

  typedef enum {PH_FREE, PH_SEND_GAPS, PH_RECV_STALLS, PH_BOTH, PH_PRESSURE} traffic_t;
  typedef enum {SET_SPREAD, SET_CLUSTER, SET_DUP} set_shape_t;

  // One point word as offered on the input channel
  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic                   last;
  } point_word_t;

  // Minimum pair of one closed set
  typedef struct {
    logic [DSQ_W-1:0]  dsq;
    logic [ROOT_W-1:0] root;
    logic              no_pair;
    logic              ovf;
  } pair_min_t;

  logic clk;
  logic rst;

  point_if  pt_bus();
  result_if res_bus();

  closest_pair_min_distance_top DUT (
    .clk (clk),
    .rst (rst),
    .pt  (pt_bus),
    .res (res_bus)
  );

  // Words still to be offered, minima still owed by the block
  point_word_t point_words[$];
  pair_min_t   set_minima_q[$];

  // Shadow of the point store for the set being loaded
  logic signed [PT_W-1:0] set_x [MAX_POINTS];
  logic signed [PT_W-1:0] set_y [MAX_POINTS];
  int unsigned            n_pts   = 0;
  bit                     dropped = 0;

  traffic_t    phase      = PH_FREE;
  int unsigned hold_left  = 0;
  bit          hold_taken = 0;
  int          failures   = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: the overflow set alone is by far the longest run, everything else
  // is small; this leaves several times its length as margin.
  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // floor(sqrt(dsq) * 256), built bit by bit from the top
  function automatic logic [ROOT_W-1:0] fixed_root(longint unsigned dsq);
    longint unsigned rad;
    longint unsigned r;
    longint unsigned t;
    rad = dsq << (2 * FRAC_W);
    r   = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= rad) r = t;
    end
    return r[ROOT_W-1:0];
  endfunction

  // Brute-force walk over every stored pair, then clear the set
  function automatic void close_set();
    pair_min_t m;
    longint    best;
    longint    d;
    longint    dx;
    longint    dy;
    bit        found;
    found = 1'b0;
    best  = 0;
    for (int i = 0; i < n_pts; i++) begin
      for (int j = i + 1; j < n_pts; j++) begin
        dx = longint'(set_x[i]) - longint'(set_x[j]);
        dy = longint'(set_y[i]) - longint'(set_y[j]);
        d  = dx * dx + dy * dy;
        if (!found || d < best) begin
          best  = d;
          found = 1'b1;
        end
      end
    end
    m.dsq     = found ? best[DSQ_W-1:0] : '0;
    m.root    = found ? fixed_root(best) : '0;
    m.no_pair = !found;
    m.ovf     = dropped;
    set_minima_q.push_back(m);
    n_pts   = 0;
    dropped = 1'b0;
  endfunction

  // Store an accepted word; a full store drops it but a last word still closes
  function automatic void take_point(logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y,
                                     logic last);
    if (n_pts < MAX_POINTS) begin
      set_x[n_pts] = x;
      set_y[n_pts] = y;
      n_pts++;
    end else begin
      dropped = 1'b1;
    end
    if (last) close_set();
  endfunction

  // ---------------------------------------------------------------------------
  // Traffic shaping
  // ---------------------------------------------------------------------------

  function automatic int gap_pct(traffic_t p);
    case (p)
      PH_SEND_GAPS: return HEAVY_PCT;
      PH_BOTH:      return LIGHT_PCT;
      default:      return 0;
    endcase
  endfunction

  function automatic int stall_pct(traffic_t p);
    case (p)
      PH_RECV_STALLS: return HEAVY_PCT;
      PH_BOTH:        return LIGHT_PCT;
      default:        return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Point driver: holds payload while stalled, junk on the bus when idle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_points
    point_word_t word;
    if (rst) begin
      pt_bus.valid <= 1'b0;
    end else if (!pt_bus.valid || pt_bus.ready) begin
      if (point_words.size() != 0 && $urandom_range(99) >= gap_pct(phase)) begin
        word = point_words.pop_front();
        pt_bus.valid      <= 1'b1;
        pt_bus.point_x    <= word.x;
        pt_bus.point_y    <= word.y;
        pt_bus.last_point <= word.last;
      end else begin
        pt_bus.valid      <= 1'b0;
        pt_bus.point_x    <= PT_W'($urandom);
        pt_bus.point_y    <= PT_W'($urandom);
        pt_bus.last_point <= 1'($urandom);
      end
    end
  end

  // Accepted words feed the predictor
  always @(posedge clk) begin
    if (!rst && pt_bus.valid && pt_bus.ready)
      take_point(pt_bus.point_x, pt_bus.point_y, pt_bus.last_point);
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold-off in the pressure mix
  // so the block backs up into its input channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
      hold_left     <= 0;
    end else if (hold_left != 0) begin
      res_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (phase == PH_PRESSURE && !hold_taken) begin
      res_bus.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_taken    <= 1'b1;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= stall_pct(phase));
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    pair_min_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (set_minima_q.size() == 0) begin
        $display("%0t: result word with no set closed: dsq %0d, dist %0d", $time,
                 res_bus.min_dist_squared, res_bus.min_distance);
        failures++;
      end else begin
        want = set_minima_q.pop_front();
        check_field("min_dist_squared", want.dsq,     res_bus.min_dist_squared);
        check_field("min_distance",     want.root,    res_bus.min_distance);
        check_field("no_pair",          want.no_pair, res_bus.no_pair);
        check_field("overflowed",       want.ovf,     res_bus.overflowed);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers (called at the falling edge, away from the driver)
  // ---------------------------------------------------------------------------
  function automatic void add_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y, bit last);
    point_word_t w;
    w.x    = x;
    w.y    = y;
    w.last = last;
    point_words.push_back(w);
  endfunction

  // One set of n points; clustered sets give small, varied distances,
  // dup sets end on a copy of an earlier point.
  function automatic void queue_set(int n, set_shape_t shape);
    logic [PT_W-1:0] xs[$];
    logic [PT_W-1:0] ys[$];
    logic [PT_W-1:0] cx;
    logic [PT_W-1:0] cy;
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
    int              span;
    int              pick;
    cx   = PT_W'($urandom);
    cy   = PT_W'($urandom);
    span = $urandom_range(1, 300);
    for (int k = 0; k < n; k++) begin
      if (shape == SET_SPREAD) begin
        x = PT_W'($urandom);
        y = PT_W'($urandom);
      end else if (shape == SET_DUP && k == n - 1 && n > 1) begin
        pick = $urandom_range(0, n - 2);
        x = xs[pick];
        y = ys[pick];
      end else begin
        x = cx + PT_W'($urandom_range(0, span));
        y = cy + PT_W'($urandom_range(0, span));
      end
      xs.push_back(x);
      ys.push_back(y);
      add_point(x, y, k == n - 1);
    end
  endfunction

  task automatic wait_quiet();
    while (point_words.size() != 0 || pt_bus.valid || set_minima_q.size() != 0)
      @(negedge clk);
  endtask

  // Random sets under one traffic mix; mostly small, now and then a big one
  task automatic run_mix(traffic_t p, int items);
    int         added;
    int         n;
    int         roll;
    set_shape_t shape;
    phase = p;
    added = 0;
    while (added < items) begin
      n    = ($urandom_range(39) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 24);
      roll = $urandom_range(9);
      shape = (roll < 5) ? SET_CLUSTER : (roll < 9) ? SET_SPREAD : SET_DUP;
      queue_set(n, shape);
      added += n;
    end
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [PT_W-1:0] fx;
    logic [PT_W-1:0] fy;

    rst               = 1'b1;
    pt_bus.valid      = 1'b0;
    pt_bus.point_x    = '0;
    pt_bus.point_y    = '0;
    pt_bus.last_point = 1'b0;
    res_bus.ready     = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed sets, no idling
    phase = PH_FREE;
    // lone point: no pair
    add_point(16'h8000, 16'h7fff, 1);
    // opposite corners: largest possible distance
    add_point(16'h8000, 16'h8000, 0);
    add_point(16'h7fff, 16'h7fff, 1);
    add_point(16'h7fff, 16'h8000, 0);
    add_point(16'h8000, 16'h7fff, 1);
    // full width along x only
    add_point(16'h8000, 16'h0000, 0);
    add_point(16'h7fff, 16'h0000, 1);
    // coincident points among others
    add_point(16'h0000, 16'h0000, 0);
    add_point(16'h0005, 16'h0005, 0);
    add_point(16'h0000, 16'h0000, 1);
    // unit diagonal across zero: root of 2
    add_point(16'hffff, 16'hffff, 0);
    add_point(16'h0000, 16'h0000, 1);
    // 3-4-5 pair plus a far point
    add_point(16'd100, 16'd200, 0);
    add_point(16'd103, 16'd204, 0);
    add_point(-16'sd5000, 16'd7, 1);
    wait_quiet();

    // Store overflow: fill the store, then a dropped word and a dropped last
    // word, both on top of point 0 so a wrongly stored one would give zero.
    fx = PT_W'($urandom);
    fy = PT_W'($urandom);
    add_point(fx, fy, 0);
    for (int k = 1; k < MAX_POINTS; k++)
      add_point(PT_W'($urandom), PT_W'($urandom), 0);
    add_point(fx, fy, 0);
    add_point(fx, fy, 1);
    wait_quiet();

    run_mix(PH_FREE,        MIX_ITEMS);
    run_mix(PH_SEND_GAPS,   MIX_ITEMS);
    run_mix(PH_RECV_STALLS, MIX_ITEMS);
    run_mix(PH_BOTH,        MIX_ITEMS);

    // Back-pressure: sets queued up while the receiver holds off
    for (int s = 0; s < 4; s++)
      queue_set(6, SET_CLUSTER);
    phase = PH_PRESSURE;
    wait_quiet();

    // Catch any stray result words
    repeat (TAIL_CYCLES) @(negedge clk);
    if (failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cpmd_pkg.sv
rtl/core/cpmd_if.sv
rtl/core/cpmd_store.sv
rtl/core/cpmd_dist.sv
rtl/core/cpmd_sqrt.sv
rtl/core/closest_pair_min_distance_top.sv
dv/closest_pair_min_distance_top_tb.sv
